FILE: hdl/vbcc_pkg.sv
// ----------------------------------------------------------------------------
// vbcc_pkg: shared types and constants
// Field widths, result kind codes and the controller-to-datapath command set
// of the voxel bounding box / centroid / covariance block.
// ----------------------------------------------------------------------------
package vbcc_pkg;

	localparam int COORD_W = 10;
	localparam int VAL_W   = 27;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 3;
	// quotient bits of the shared divider
	localparam int QUOT_W  = 28;

	localparam logic [KIND_W-1:0] KIND_MIN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MAX = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BAR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_VAR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_COV = 3'd4;

	localparam logic [IDX_W-1:0] LAST_AXIS  = 3'd2;
	localparam logic [IDX_W-1:0] LAST_ENTRY = 3'd5;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              acc;
		logic              clr;
		logic              bar_start;
		logic              bar_store;
		logic              cov_mul;
		logic              cov_sum;
		logic              cov_start;
		logic              cov_store;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage

FILE: hdl/vbcc_in_if.sv
// ----------------------------------------------------------------------------
// vbcc_in_if: voxel input channel
// One voxel coordinate triple per request, with the end-of-set flag.
// ----------------------------------------------------------------------------
interface vbcc_in_if;
	logic                             valid;
	logic                             ready;
	logic [vbcc_pkg::COORD_W-1:0]     coord_x;
	logic [vbcc_pkg::COORD_W-1:0]     coord_y;
	logic [vbcc_pkg::COORD_W-1:0]     coord_z;
	logic                             set_end;

	modport source (output valid, coord_x, coord_y, coord_z, set_end, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, set_end, output ready);
endinterface

FILE: hdl/vbcc_out_if.sv
// ----------------------------------------------------------------------------
// vbcc_out_if: result output channel
// One statistics result per request: kind code and three signed values.
// ----------------------------------------------------------------------------
interface vbcc_out_if;
	logic                             valid;
	logic                             ready;
	logic [vbcc_pkg::KIND_W-1:0]      kind;
	logic signed [vbcc_pkg::VAL_W-1:0] value_a;
	logic signed [vbcc_pkg::VAL_W-1:0] value_b;
	logic signed [vbcc_pkg::VAL_W-1:0] value_c;
	logic                             final_result;

	modport source (output valid, kind, value_a, value_b, value_c, final_result,
		input ready);
	modport sink (input valid, kind, value_a, value_b, value_c, final_result,
		output ready);
endinterface

FILE: hdl/vbcc_div.sv
// ----------------------------------------------------------------------------
// vbcc_div: shared restoring divider
// Produces QUOT_W quotient bits, one per cycle, from a shifted divisor.
// ----------------------------------------------------------------------------
module vbcc_div #(
	parameter int WW   = 64,
	parameter int DENW = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [WW-1:0]                 num,
	input  logic [DENW-1:0]               den,
	output logic                          done,
	output logic [vbcc_pkg::QUOT_W-1:0]   quot
);
	localparam int QW  = vbcc_pkg::QUOT_W;
	localparam int CNW = $clog2(QW);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [WW-1:0]  rem_q;
	logic [WW-1:0]  dsh_q;
	logic [QW-1:0]  quot_q;
	logic           ge;

	assign ge   = (rem_q >= dsh_q);
	assign done = done_q;
	assign quot = quot_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder, shifted divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= WW'(den) << (QW - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end
endmodule

FILE: hdl/vbcc_ctrl.sv
// ----------------------------------------------------------------------------
// vbcc_ctrl: sequencing controller
// Accumulates voxels, then steps the barycenter divisions, the covariance
// entries and the five result requests.
// ----------------------------------------------------------------------------
module vbcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_set_end,
	input  logic                out_ready,
	input  vbcc_pkg::stat_t     stat,
	output vbcc_pkg::cmd_t      cmd,
	output logic                in_ready,
	output logic                out_valid
);
	typedef enum logic [2:0] {
		S_ACC, S_BDIV, S_BWAIT, S_CMUL, S_CSUM, S_CFIN, S_CWAIT, S_EMIT
	} state_t;

	state_t                         state_q;
	logic [vbcc_pkg::IDX_W-1:0]     idx_q;
	logic                           in_take;
	logic                           out_take;

	assign in_ready  = (state_q == S_ACC);
	assign out_valid = (state_q == S_EMIT);
	assign in_take   = in_valid && in_ready;
	assign out_take  = out_valid && out_ready;

	// decode commands
	always_comb begin
		cmd           = '0;
		cmd.idx       = idx_q;
		cmd.acc       = in_take;
		cmd.clr       = out_take && (idx_q == vbcc_pkg::KIND_COV);
		cmd.bar_start = (state_q == S_BDIV);
		cmd.bar_store = (state_q == S_BWAIT) && stat.div_done;
		cmd.cov_mul   = (state_q == S_CMUL);
		cmd.cov_sum   = (state_q == S_CSUM);
		cmd.cov_start = (state_q == S_CFIN);
		cmd.cov_store = (state_q == S_CWAIT) && stat.div_done;
	end

	// hold state and entry index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_ACC: begin
					if (in_take && in_set_end) begin
						idx_q   <= '0;
						state_q <= S_BDIV;
					end
				end
				S_BDIV: state_q <= S_BWAIT;
				S_BWAIT: begin
					if (stat.div_done) begin
						if (idx_q == vbcc_pkg::LAST_AXIS) begin
							idx_q   <= '0;
							state_q <= S_CMUL;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_BDIV;
						end
					end
				end
				S_CMUL: state_q <= S_CSUM;
				S_CSUM: state_q <= S_CFIN;
				S_CFIN: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (stat.div_done) begin
						if (idx_q == vbcc_pkg::LAST_ENTRY) begin
							idx_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_CMUL;
						end
					end
				end
				S_EMIT: begin
					if (out_take) begin
						if (idx_q == vbcc_pkg::KIND_COV) begin
							idx_q   <= '0;
							state_q <= S_ACC;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end
endmodule

FILE: hdl/vbcc_dpath.sv
// ----------------------------------------------------------------------------
// vbcc_dpath: statistics datapath
// Accumulators, barycenter and covariance registers, the covariance product
// pipeline, the shared divider and the result selection.
// ----------------------------------------------------------------------------
module vbcc_dpath #(
	parameter int GRID_SIZE  = 1024,
	parameter int MAX_VOXELS = 65536,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vbcc_pkg::cmd_t                        cmd,
	output vbcc_pkg::stat_t                       stat,
	input  logic [vbcc_pkg::COORD_W-1:0]          coord_x,
	input  logic [vbcc_pkg::COORD_W-1:0]          coord_y,
	input  logic [vbcc_pkg::COORD_W-1:0]          coord_z,
	output logic [vbcc_pkg::KIND_W-1:0]           kind,
	output logic signed [vbcc_pkg::VAL_W-1:0]     value_a,
	output logic signed [vbcc_pkg::VAL_W-1:0]     value_b,
	output logic signed [vbcc_pkg::VAL_W-1:0]     value_c,
	output logic                                  final_result
);
	localparam int CWD  = vbcc_pkg::COORD_W;
	localparam int VW   = vbcc_pkg::VAL_W;
	localparam int QW   = vbcc_pkg::QUOT_W;
	localparam int CW   = $clog2(MAX_VOXELS + 1);
	localparam int SW   = CW + CWD;
	localparam int QSW  = CW + 2 * CWD;
	localparam int PW   = CW + 2 * CWD;
	localparam int CV   = CW + 2 * CWD + 3;
	localparam int WW   = CW + 30 + FRAC_BITS;
	localparam int DENW = CW + 1;
	localparam int GMAX = (GRID_SIZE - 1 > 1023) ? 1023 : GRID_SIZE - 1;
	localparam logic [QW-1:0] POS_LIM = QW'((1 << (VW - 1)) - 1);
	localparam logic [QW-1:0] NEG_LIM = QW'(1 << (VW - 1));

	logic [CWD-1:0] p [3];
	logic [CW-1:0]  cnt_q;
	logic [CWD-1:0] mn_q  [3];
	logic [CWD-1:0] mx_q  [3];
	logic [SW-1:0]  sum_q [3];
	logic [QSW-1:0] sq_q  [3];
	logic [QSW-1:0] cr_q  [3];
	logic [CWD-1:0] bar_q [3];
	logic [VW-1:0]  cov_q [6];
	logic [2*CWD-1:0] sqp [3];
	logic [2*CWD-1:0] crp [3];

	logic [CWD-1:0]  bu, bv;
	logic [SW-1:0]   su, sv, bsum;
	logic [QSW-1:0]  suv;
	logic [PW-1:0]   p1_s1, p2_s1;
	logic [2*CWD-1:0] p3_s1;
	logic signed [CV-1:0] s_s2, p4_s2, cval;
	logic [CV-1:0]   cmag;
	logic            neg_q;
	logic [WW-1:0]   dnum;
	logic [DENW-1:0] dden;
	logic            div_done;
	logic [QW-1:0]   quot;
	logic [QW-1:0]   qmag;
	logic [VW-1:0]   cres;

	// saturate coordinates to the grid
	assign p[0] = (coord_x > CWD'(GMAX)) ? CWD'(GMAX) : coord_x;
	assign p[1] = (coord_y > CWD'(GMAX)) ? CWD'(GMAX) : coord_y;
	assign p[2] = (coord_z > CWD'(GMAX)) ? CWD'(GMAX) : coord_z;

	assign sqp[0] = p[0] * p[0];
	assign sqp[1] = p[1] * p[1];
	assign sqp[2] = p[2] * p[2];
	assign crp[0] = p[0] * p[1];
	assign crp[1] = p[0] * p[2];
	assign crp[2] = p[1] * p[2];

	// accumulate voxels up to the set limit, clear after the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int a = 0; a < 3; a++) begin
				mn_q[a]  <= '1;
				mx_q[a]  <= '0;
				sum_q[a] <= '0;
				sq_q[a]  <= '0;
				cr_q[a]  <= '0;
			end
		end else if (cmd.clr) begin
			cnt_q <= '0;
			for (int a = 0; a < 3; a++) begin
				mn_q[a]  <= '1;
				mx_q[a]  <= '0;
				sum_q[a] <= '0;
				sq_q[a]  <= '0;
				cr_q[a]  <= '0;
			end
		end else if (cmd.acc && (cnt_q < CW'(MAX_VOXELS))) begin
			cnt_q <= cnt_q + 1'b1;
			for (int a = 0; a < 3; a++) begin
				if (p[a] < mn_q[a]) mn_q[a] <= p[a];
				if (p[a] > mx_q[a]) mx_q[a] <= p[a];
				sum_q[a] <= sum_q[a] + SW'(p[a]);
				sq_q[a]  <= sq_q[a] + QSW'(sqp[a]);
				cr_q[a]  <= cr_q[a] + QSW'(crp[a]);
			end
		end
	end

	// pick the sum for one barycenter axis
	always_comb begin
		unique case (cmd.idx)
			3'd0:    bsum = sum_q[0];
			3'd1:    bsum = sum_q[1];
			default: bsum = sum_q[2];
		endcase
	end

	// pick the axis pair of one covariance entry
	always_comb begin
		unique case (cmd.idx)
			3'd1: begin
				bu = bar_q[1]; bv = bar_q[1]; su = sum_q[1]; sv = sum_q[1]; suv = sq_q[1];
			end
			3'd2: begin
				bu = bar_q[2]; bv = bar_q[2]; su = sum_q[2]; sv = sum_q[2]; suv = sq_q[2];
			end
			3'd3: begin
				bu = bar_q[0]; bv = bar_q[1]; su = sum_q[0]; sv = sum_q[1]; suv = cr_q[0];
			end
			3'd4: begin
				bu = bar_q[0]; bv = bar_q[2]; su = sum_q[0]; sv = sum_q[2]; suv = cr_q[1];
			end
			3'd5: begin
				bu = bar_q[1]; bv = bar_q[2]; su = sum_q[1]; sv = sum_q[2]; suv = cr_q[2];
			end
			default: begin
				bu = bar_q[0]; bv = bar_q[0]; su = sum_q[0]; sv = sum_q[0]; suv = sq_q[0];
			end
		endcase
	end

	// centered sum: Suv - bu*Sv - bv*Su + n*bu*bv, over three stages
	always_ff @(posedge clk) begin
		if (cmd.cov_mul) begin
			p1_s1 <= PW'(bu * sv);
			p2_s1 <= PW'(bv * su);
			p3_s1 <= bu * bv;
		end
		if (cmd.cov_sum) begin
			s_s2  <= $signed(CV'(suv)) - $signed(CV'(p1_s1)) - $signed(CV'(p2_s1));
			p4_s2 <= $signed(CV'(cnt_q * p3_s1));
		end
		if (cmd.cov_start) begin
			neg_q <= cval[CV-1];
		end
	end

	assign cval = s_s2 + p4_s2;
	assign cmag = cval[CV-1] ? CV'(-cval) : CV'(cval);

	// divider operands
	always_comb begin
		if (cmd.cov_start) begin
			dnum = WW'(cmag) << FRAC_BITS;
			dden = DENW'(cnt_q);
		end else begin
			dnum = WW'({bsum, 1'b0}) + WW'(cnt_q);
			dden = {cnt_q, 1'b0};
		end
	end

	vbcc_div #(
		.WW   (WW),
		.DENW (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.bar_start || cmd.cov_start),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quot   (quot)
	);

	assign stat.div_done = div_done;

	// clamp the quotient into the signed result range
	always_comb begin
		if (neg_q) begin
			qmag = (quot > NEG_LIM) ? NEG_LIM : quot;
			cres = VW'(-qmag);
		end else begin
			qmag = (quot > POS_LIM) ? POS_LIM : quot;
			cres = VW'(qmag);
		end
	end

	// store barycenters and covariance entries
	always_ff @(posedge clk) begin
		if (cmd.bar_store) begin
			unique case (cmd.idx)
				3'd0:    bar_q[0] <= quot[CWD-1:0];
				3'd1:    bar_q[1] <= quot[CWD-1:0];
				default: bar_q[2] <= quot[CWD-1:0];
			endcase
		end
		if (cmd.cov_store) begin
			unique case (cmd.idx)
				3'd1:    cov_q[1] <= cres;
				3'd2:    cov_q[2] <= cres;
				3'd3:    cov_q[3] <= cres;
				3'd4:    cov_q[4] <= cres;
				3'd5:    cov_q[5] <= cres;
				default: cov_q[0] <= cres;
			endcase
		end
	end

	// select the result under request
	assign kind         = cmd.idx;
	assign final_result = (cmd.idx == vbcc_pkg::KIND_COV);
	always_comb begin
		unique case (cmd.idx)
			vbcc_pkg::KIND_MIN: begin
				value_a = VW'(mn_q[0]); value_b = VW'(mn_q[1]); value_c = VW'(mn_q[2]);
			end
			vbcc_pkg::KIND_MAX: begin
				value_a = VW'(mx_q[0]); value_b = VW'(mx_q[1]); value_c = VW'(mx_q[2]);
			end
			vbcc_pkg::KIND_BAR: begin
				value_a = VW'(bar_q[0]); value_b = VW'(bar_q[1]); value_c = VW'(bar_q[2]);
			end
			vbcc_pkg::KIND_VAR: begin
				value_a = cov_q[0]; value_b = cov_q[1]; value_c = cov_q[2];
			end
			default: begin
				value_a = cov_q[3]; value_b = cov_q[4]; value_c = cov_q[5];
			end
		endcase
	end
endmodule

FILE: hdl/voxel_bbox_centroid_covariance.sv
// ----------------------------------------------------------------------------
// voxel_bbox_centroid_covariance: voxel set statistics
// Bounding box, rounded barycenter and Q.FRAC_BITS covariance of a voxel set.
// ----------------------------------------------------------------------------
// Usage:
//   voxel  : one voxel (coord_x, coord_y, coord_z) per request; set_end marks
//            the last voxel of a set. One voxel is taken per cycle while the
//            block accumulates; voxels past MAX_VOXELS are dropped.
//   result : five requests per set, in order min, max, barycenter, variances,
//            covariances; final_result flags the covariance request.
// Sequencing: after the set_end voxel the block runs nine divisions on one
//   shared restoring divider (three barycenters, six covariance entries),
//   each covariance entry preceded by its product and sum steps, before
//   the first result is offered.
// Throughput: one voxel per cycle inside a set; no voxel is taken from the
//   set_end voxel until the last result has been taken.
// Reset clears all accumulators to an empty set and returns to accumulation.
// A stalled receiver holds the current result steady until it is taken.
// ----------------------------------------------------------------------------
module voxel_bbox_centroid_covariance #(
	parameter int GRID_SIZE  = 1024,
	parameter int MAX_VOXELS = 65536,
	parameter int FRAC_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	vbcc_in_if.sink     voxel,
	vbcc_out_if.source  result
);
	vbcc_pkg::cmd_t  cmd;
	vbcc_pkg::stat_t stat;

	vbcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (voxel.valid),
		.in_set_end (voxel.set_end),
		.out_ready  (result.ready),
		.stat       (stat),
		.cmd        (cmd),
		.in_ready   (voxel.ready),
		.out_valid  (result.valid)
	);

	vbcc_dpath #(
		.GRID_SIZE  (GRID_SIZE),
		.MAX_VOXELS (MAX_VOXELS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.coord_x      (voxel.coord_x),
		.coord_y      (voxel.coord_y),
		.coord_z      (voxel.coord_z),
		.kind         (result.kind),
		.value_a      (result.value_a),
		.value_b      (result.value_b),
		.value_c      (result.value_c),
		.final_result (result.final_result)
	);

	// no voxel is taken while results are pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(voxel.ready && result.valid))
		else $error("voxel taken while results pending");

	// the final flag sits on the covariance result only
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.final_result |-> result.kind == vbcc_pkg::KIND_COV)
		else $error("final flag on wrong result kind");

	// after the last result the block accepts voxels again
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.final_result |=> voxel.ready)
		else $error("block did not resume after last result");

	// results follow in kind order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.final_result |=>
		result.valid && result.kind == $past(result.kind) + 3'd1)
		else $error("result kinds out of order");
endmodule
